// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros shared by the checker files of this project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// A trigger that requires a consequence in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, trig, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) else $error(msg);

// A trigger that requires a consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst, trig, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/tbbsq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbbsq_pkg
// Shared constants, types and codes of the time and byte bounded snapshot
// queue.
// ----------------------------------------------------------------------------
package tbbsq_pkg;

   // Queue geometry.
   localparam int QUEUE_DEPTH = 256;
   localparam int ADDR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

   // Field widths.
   localparam int OP_W       = 2;
   localparam int STAMP_W    = 63;
   localparam int SIZE_W     = 24;
   localparam int HANDLE_W   = 32;
   localparam int BYTES_W    = 40;
   localparam int LIMIT_W    = 32;
   localparam int WINDOW_W   = 62;
   localparam int OVH_W      = 8;
   localparam int EVICT_W    = 9;
   localparam int OUT_CNT_W  = 9;

   // Stream and register port widths.
   localparam int REQ_DATA_W  = 120;
   localparam int RSP_DATA_W  = 184;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 62;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
   localparam logic [OP_W-1:0] OP_POP   = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_BYTE_LIMIT_ENABLE = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BYTE_LIMIT        = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_ENABLE     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_LENGTH     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ENTRY_OVERHEAD    = 3'd4;

   localparam logic [OVH_W-1:0] OVERHEAD_RESET = 8'd32;

   // One stored message descriptor.
   typedef struct packed {
      logic [HANDLE_W-1:0] handle;
      logic [SIZE_W-1:0]   size;
      logic [STAMP_W-1:0]  stamp;
   } entry_type;

   // Configuration register contents.
   typedef struct packed {
      logic                byte_limit_enable;
      logic [LIMIT_W-1:0]  byte_limit;
      logic                window_enable;
      logic [WINDOW_W-1:0] window_length;
      logic [OVH_W-1:0]    entry_overhead;
   } cfg_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_item;
      logic clear_queue;
      logic set_backstep;
      logic pop;
      logic evict;
      logic append;
      logic emit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic backstep_hit;
      logic oversize;
      logic empty;
      logic evict_needed;
      logic out_free;
   } status_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_EVICT = 3'b010,
      ST_DONE  = 3'b100
   } state_type;

endpackage

// ----- hw/rtl/tbbsq_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbbsq_ctrl
// Sequencer of the snapshot queue: takes one transaction, steps the
// datapath through evictions and the append, and hands off the response.
// ----------------------------------------------------------------------------
module tbbsq_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [tbbsq_pkg::OP_W-1:0]  req_op,
   input  tbbsq_pkg::status_type       status,
   output tbbsq_pkg::cmd_type          cmd
);
   import tbbsq_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   // Next state and command decode.
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load_item = 1'b1;
               state_in      = ST_DONE;
               unique case (req_op)
                  OP_PUSH: begin
                     cmd.clear_queue  = status.backstep_hit;
                     cmd.set_backstep = status.backstep_hit;
                     if (!status.oversize) begin
                        state_in = ST_EVICT;
                     end
                  end
                  OP_POP: begin
                     cmd.pop = !status.empty;
                  end
                  OP_CLEAR: begin
                     cmd.clear_queue = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_EVICT: begin
            // One eviction per cycle, then the append.
            if (status.evict_needed) begin
               cmd.evict = 1'b1;
            end else begin
               cmd.append = 1'b1;
               state_in   = ST_DONE;
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- hw/rtl/tbbsq_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbbsq_datapath
// Entry ring memory, head and count pointers, byte accounting, limit
// checks and the response register of the snapshot queue.
// ----------------------------------------------------------------------------
module tbbsq_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  tbbsq_pkg::cfg_type                cfg,
   input  logic [tbbsq_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  tbbsq_pkg::cmd_type                cmd,
   output tbbsq_pkg::status_type             status,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [tbbsq_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import tbbsq_pkg::*;

   localparam logic [ADDR_W-1:0]  LAST_SLOT = ADDR_W'(QUEUE_DEPTH - 1);
   localparam logic [COUNT_W-1:0] FULL_CNT  = COUNT_W'(QUEUE_DEPTH);
   localparam logic [COUNT_W:0]   DEPTH_EXT = (COUNT_W + 1)'(QUEUE_DEPTH);

   // Ring storage.
   entry_type mem [QUEUE_DEPTH];

   // Request fields.
   logic [STAMP_W-1:0]  req_stamp;
   logic [SIZE_W-1:0]   req_size;
   logic [HANDLE_W-1:0] req_handle;

   // Latched item.
   logic [STAMP_W-1:0]  item_stamp_ff;
   logic [SIZE_W-1:0]   item_size_ff;
   logic [HANDLE_W-1:0] item_handle_ff;

   // Queue state.
   logic [ADDR_W-1:0]   head_ff, head_in, head_wrap;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [BYTES_W-1:0]  bytes_ff, bytes_in;
   logic [STAMP_W-1:0]  last_stamp_ff;
   entry_type           rd_ff;

   // Result under construction.
   logic                res_accepted_ff;
   logic                res_backstep_ff;
   logic [EVICT_W-1:0]  res_evicted_ff;
   logic                res_valid_ff;
   entry_type           res_entry_ff;

   // Response register.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   // Arithmetic.
   logic                dropping;
   logic [SIZE_W:0]     drop_cost;
   logic [BYTES_W-1:0]  drop_bytes;
   logic [BYTES_W-1:0]  append_bytes;
   logic [COUNT_W:0]    tail_sum;
   logic [ADDR_W-1:0]   tail;
   logic [BYTES_W:0]    byte_need;
   logic [STAMP_W-1:0]  span;
   logic                byte_hit, window_hit;
   entry_type           wr_entry;

   assign req_stamp  = req_tdata[STAMP_W-1:0];
   assign req_size   = req_tdata[STAMP_W+SIZE_W-1:STAMP_W];
   assign req_handle = req_tdata[STAMP_W+SIZE_W+HANDLE_W-1:STAMP_W+SIZE_W];

   // Removal of the oldest entry: cost saturates, an emptied queue holds 0.
   assign dropping   = cmd.pop || cmd.evict;
   assign drop_cost  = {1'b0, rd_ff.size} + (SIZE_W + 1)'(cfg.entry_overhead);
   assign head_wrap  = (head_ff == LAST_SLOT) ? '0 : head_ff + 1'b1;
   always_comb begin
      if (count_ff == COUNT_W'(1)) begin
         drop_bytes = '0;
      end else if (bytes_ff > BYTES_W'(drop_cost)) begin
         drop_bytes = bytes_ff - BYTES_W'(drop_cost);
      end else begin
         drop_bytes = '0;
      end
   end

   // Append position and byte count.
   assign tail_sum     = (COUNT_W + 1)'(head_ff) + (COUNT_W + 1)'(count_ff);
   assign tail         = (tail_sum >= DEPTH_EXT) ? ADDR_W'(tail_sum - DEPTH_EXT)
                                                 : ADDR_W'(tail_sum);
   assign append_bytes = bytes_ff + BYTES_W'(item_size_ff) + BYTES_W'(cfg.entry_overhead);

   // Limit checks: byte total plus new size, and new stamp against the oldest entry.
   assign byte_need  = {1'b0, bytes_ff} + (BYTES_W + 1)'(item_size_ff);
   assign byte_hit   = cfg.byte_limit_enable &&
                       (byte_need > (BYTES_W + 1)'(cfg.byte_limit));
   assign span       = item_stamp_ff - rd_ff.stamp;
   assign window_hit = cfg.window_enable && (item_stamp_ff > rd_ff.stamp) &&
                       (span > STAMP_W'(cfg.window_length));

   // Status toward the controller.
   always_comb begin
      status.backstep_hit = (count_ff != '0) && (req_stamp < last_stamp_ff);
      status.oversize     = cfg.byte_limit_enable &&
                            (LIMIT_W'(req_size) > cfg.byte_limit);
      status.empty        = (count_ff == '0);
      status.evict_needed = (count_ff != '0) &&
                            (byte_hit || window_hit || (count_ff == FULL_CNT));
      status.out_free     = !rsp_valid_ff || rsp_tready;
   end

   // Next head, count and byte total.
   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      bytes_in = bytes_ff;
      if (cmd.clear_queue) begin
         head_in  = '0;
         count_in = '0;
         bytes_in = '0;
      end else if (dropping) begin
         head_in  = head_wrap;
         count_in = count_ff - 1'b1;
         bytes_in = drop_bytes;
      end else if (cmd.append) begin
         count_in = count_ff + 1'b1;
         bytes_in = append_bytes;
      end
   end

   assign wr_entry = '{handle: item_handle_ff, size: item_size_ff, stamp: item_stamp_ff};

   // Ring write, and a registered read that follows the head.
   always_ff @(posedge clock) begin
      if (cmd.append) begin
         mem[tail] <= wr_entry;
      end
      if (cmd.append && (tail == head_in)) begin
         rd_ff <= wr_entry;
      end else begin
         rd_ff <= mem[head_in];
      end
   end

   // Queue control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
         bytes_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
         bytes_ff <= bytes_in;
      end
   end

   // Item latch, newest stamp and result fields.
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         item_stamp_ff   <= req_stamp;
         item_size_ff    <= req_size;
         item_handle_ff  <= req_handle;
         res_accepted_ff <= 1'b0;
         res_backstep_ff <= cmd.set_backstep;
         res_evicted_ff  <= '0;
         res_valid_ff    <= cmd.pop;
         res_entry_ff    <= cmd.pop ? rd_ff : '0;
      end
      if (cmd.evict) begin
         res_evicted_ff <= res_evicted_ff + 1'b1;
      end
      if (cmd.append) begin
         res_accepted_ff <= 1'b1;
         last_stamp_ff   <= item_stamp_ff;
      end
   end

   // Response register: loaded once per transaction, held while stalled.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_data_ff <= {4'b0, bytes_ff, OUT_CNT_W'(count_ff),
                         res_entry_ff.size, res_entry_ff.stamp, res_entry_ff.handle,
                         res_valid_ff, res_evicted_ff, res_backstep_ff,
                         res_accepted_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ----- hw/rtl/time_and_byte_bounded_snapshot_queue_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// time_and_byte_bounded_snapshot_queue_top
// Snapshot FIFO of timestamped message descriptors with a byte budget and
// a time window that evict the oldest entries on push.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake              Carries
//   req_*     in         req_tvalid/req_tready  operation, stamp, size, handle
//   rsp_*     out        rsp_tvalid/rsp_tready  one result per transaction
//   csr_*     in         csr_write_enable       register index and value
//
// Pop, clear, unused codes and a dropped push go from acceptance straight to the
// result; a stored push first evicts the entries it must, one per cycle through the
// single head read port of the ring memory, and then appends the new entry.
// Reset is synchronous; the ring memory is not cleared, only pointers.
// The result waits in an output register, so a new transaction is taken
// while an earlier result is still stalled.
module time_and_byte_bounded_snapshot_queue_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // stamp[62:0], payload_bytes[86:63], handle[118:87], zero pad
   input  logic [tbbsq_pkg::REQ_DATA_W-1:0]     req_tdata,
   // operation[1:0]
   input  logic [tbbsq_pkg::OP_W-1:0]           req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // accepted[0], cleared_by_backstep[1], evicted_count[10:2], out_valid[11],
   // out_handle[43:12], out_stamp[106:44], out_bytes[130:107],
   // entry_count[139:131], byte_total[179:140], zero pad
   output logic [tbbsq_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                 csr_write_enable,
   input  logic [tbbsq_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [tbbsq_pkg::CSR_DATA_W-1:0]     csr_write_data
);
   import tbbsq_pkg::*;

   cfg_type    cfg_ff;
   cmd_type    cmd;
   status_type status;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.byte_limit_enable <= 1'b0;
         cfg_ff.byte_limit        <= '0;
         cfg_ff.window_enable     <= 1'b0;
         cfg_ff.window_length     <= '0;
         cfg_ff.entry_overhead    <= OVERHEAD_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_BYTE_LIMIT_ENABLE: cfg_ff.byte_limit_enable <= csr_write_data[0];
            CSR_BYTE_LIMIT:        cfg_ff.byte_limit <= csr_write_data[LIMIT_W-1:0];
            CSR_WINDOW_ENABLE:     cfg_ff.window_enable <= csr_write_data[0];
            CSR_WINDOW_LENGTH:     cfg_ff.window_length <= csr_write_data[WINDOW_W-1:0];
            CSR_ENTRY_OVERHEAD:    cfg_ff.entry_overhead <= csr_write_data[OVH_W-1:0];
            default: begin
            end
         endcase
      end
   end

   tbbsq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser),
      .status     (status),
      .cmd        (cmd)
   );

   tbbsq_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ----- hw/rtl/tbbsq_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbbsq_checker
// Port-level checks of the snapshot queue responses, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tbbsq_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [tbbsq_pkg::RSP_DATA_W-1:0]    rsp_tdata
);
   import tbbsq_pkg::*;

   logic                 accepted;
   logic [EVICT_W-1:0]   evicted;
   logic                 out_valid;
   logic [OUT_CNT_W-1:0] entry_count;
   logic [BYTES_W-1:0]   byte_total;

   assign accepted    = rsp_tdata[0];
   assign evicted     = rsp_tdata[10:2];
   assign out_valid   = rsp_tdata[11];
   assign entry_count = rsp_tdata[139:131];
   assign byte_total  = rsp_tdata[179:140];

   // A stalled result stays on the bus unchanged.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled response changed")

   // A stored push leaves at least one entry.
   `ASSERT_IMPLIES(a_accept_count, clock, reset, rsp_tvalid && accepted, entry_count != '0, "accepted push with empty queue")

   // A pop result carries no push status.
   `ASSERT_IMPLIES(a_pop_fields, clock, reset, rsp_tvalid && out_valid, !accepted && (evicted == '0), "pop result with push status")

   // An empty queue counts no bytes.
   `ASSERT_IMPLIES(a_empty_bytes, clock, reset, rsp_tvalid && (entry_count == '0), byte_total == '0, "empty queue with bytes")

   // The entry count never passes the ring depth.
   `ASSERT_IMPLIES(a_count_range, clock, reset, rsp_tvalid, entry_count <= OUT_CNT_W'(QUEUE_DEPTH), "entry count above depth")

endmodule

bind time_and_byte_bounded_snapshot_queue_top tbbsq_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the time and byte bounded snapshot queue. A
// directed opening covers the field extremes, every operation and the
// special cases; a set of random phases then runs under several register
// settings and handshake idling patterns. A behavioral copy of the queue
// predicts every result, and each result is compared field by field.
// ----------------------------------------------------------------------------
module tb;
   import tbbsq_pkg::*;

   localparam logic [OP_W-1:0]     OP_UNUSED   = 2'd3;
   localparam logic [STAMP_W-1:0]  STAMP_MAX   = {STAMP_W{1'b1}};
   localparam logic [SIZE_W-1:0]   SIZE_MAX    = {SIZE_W{1'b1}};
   localparam logic [WINDOW_W-1:0] WINDOW_MAX  = {WINDOW_W{1'b1}};
   localparam logic [39:0]         BYTES_MASK  = {40{1'b1}};
   localparam int                  STALL_LIMIT = 5000;
   localparam int                  HOLD_CYCLES = 400;
   localparam int                  SETTLE      = 8;
   localparam int                  PRINT_CAP   = 40;

   // One result of the queue, unpacked.
   typedef struct {
      logic                 accepted;
      logic                 backstep;
      logic [EVICT_W-1:0]   evicted;
      logic                 out_valid;
      logic [HANDLE_W-1:0]  out_handle;
      logic [STAMP_W-1:0]   out_stamp;
      logic [SIZE_W-1:0]    out_bytes;
      logic [OUT_CNT_W-1:0] entry_count;
      logic [BYTES_W-1:0]   byte_total;
   } queue_reply_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata;
   logic [OP_W-1:0]        req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   // Behavioral copy of the ring and its registers.
   logic [STAMP_W-1:0]  ring_stamp  [QUEUE_DEPTH];
   logic [SIZE_W-1:0]   ring_size   [QUEUE_DEPTH];
   logic [HANDLE_W-1:0] ring_handle [QUEUE_DEPTH];
   int unsigned         ring_head;
   int unsigned         ring_fill;
   longint unsigned     ring_bytes;
   cfg_type             cfg;

   queue_reply_type queue_replies[$];
   queue_reply_type want_reply;

   // Handshake shaping and bookkeeping.
   int unsigned        tx_idle_pct;
   int unsigned        rx_stall_pct;
   int unsigned        hold_off_len;
   int unsigned        hold_left;
   int unsigned        quiet_cycles;
   logic [STAMP_W-1:0] last_stamp;
   int unsigned        mismatch_count;
   int unsigned        item_count;
   int unsigned        reply_count;
   int unsigned        stored_count;
   int unsigned        dropped_count;
   int unsigned        backstep_count;
   int unsigned        evict_total;
   int unsigned        evict_peak;
   int unsigned        pop_hit_count;
   int unsigned        pop_empty_count;

   time_and_byte_bounded_snapshot_queue_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .req_tuser        (req_tuser),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Remove the oldest entry of the copy and return its slot.
   function automatic int unsigned retire_oldest();
      int unsigned     slot;
      longint unsigned cost;
      slot = ring_head % QUEUE_DEPTH;
      cost = longint'(ring_size[slot]) + longint'(cfg.entry_overhead);
      ring_bytes = (ring_bytes > cost) ? ring_bytes - cost : 0;
      ring_head = (slot + 1) % QUEUE_DEPTH;
      ring_fill--;
      if (ring_fill == 0) ring_bytes = 0;
      return slot;
   endfunction

   // Apply one transaction to the copy and return the result it causes.
   function automatic queue_reply_type compute_queue_reply(logic [OP_W-1:0] op,
         logic [STAMP_W-1:0] stamp, logic [SIZE_W-1:0] size,
         logic [HANDLE_W-1:0] handle);
      queue_reply_type    r;
      bit                 ok;
      int unsigned        slot;
      int unsigned        evicted;
      logic [STAMP_W-1:0] oldest;
      logic [STAMP_W-1:0] span;
      r = '{default: '0};
      ok = 1'b1;
      evicted = 0;
      if (op == OP_PUSH) begin
         // Time going backwards wipes the queue first.
         if (ring_fill != 0) begin
            slot = (ring_head + ring_fill - 1) % QUEUE_DEPTH;
            if (stamp < ring_stamp[slot]) begin
               ring_head = 0;
               ring_fill = 0;
               ring_bytes = 0;
               r.backstep = 1'b1;
               backstep_count++;
            end
         end
         // Byte budget: drop an oversized payload, else make room.
         if (cfg.byte_limit_enable) begin
            if (size > cfg.byte_limit) begin
               ok = 1'b0;
            end else begin
               while (ring_fill != 0 &&
                      ring_bytes + longint'(size) > longint'(cfg.byte_limit)) begin
                  void'(retire_oldest());
                  evicted++;
               end
            end
         end
         // Time window: evict entries too old relative to the new stamp.
         if (ok && cfg.window_enable) begin
            while (ring_fill != 0) begin
               oldest = ring_stamp[ring_head % QUEUE_DEPTH];
               span = (stamp >= oldest) ? stamp - oldest : '0;
               if (span <= {1'b0, cfg.window_length}) break;
               void'(retire_oldest());
               evicted++;
            end
         end
         if (ok) begin
            if (ring_fill >= QUEUE_DEPTH) begin
               void'(retire_oldest());
               evicted++;
            end
            slot = (ring_head + ring_fill) % QUEUE_DEPTH;
            ring_stamp[slot] = stamp;
            ring_size[slot] = size;
            ring_handle[slot] = handle;
            ring_fill++;
            ring_bytes = (ring_bytes + longint'(size) + longint'(cfg.entry_overhead))
                         & longint'(BYTES_MASK);
            r.accepted = 1'b1;
            stored_count++;
         end else begin
            dropped_count++;
         end
         evict_total += evicted;
         if (evicted > evict_peak) evict_peak = evicted;
      end else if (op == OP_POP) begin
         if (ring_fill != 0) begin
            slot = retire_oldest();
            r.out_valid = 1'b1;
            r.out_handle = ring_handle[slot];
            r.out_stamp = ring_stamp[slot];
            r.out_bytes = ring_size[slot];
            pop_hit_count++;
         end else begin
            pop_empty_count++;
         end
      end else if (op == OP_CLEAR) begin
         ring_head = 0;
         ring_fill = 0;
         ring_bytes = 0;
      end
      r.evicted = evicted[EVICT_W-1:0];
      r.entry_count = ring_fill[OUT_CNT_W-1:0];
      r.byte_total = ring_bytes[BYTES_W-1:0];
      return r;
   endfunction

   // Print one mismatch line (up to a cap) and count it.
   task automatic report_mismatch(string what, logic [63:0] seen, logic [63:0] want);
      mismatch_count++;
      if (mismatch_count <= PRINT_CAP)
         $display("MISMATCH at %0t: %s got 0x%0h, predicted 0x%0h",
                  $time, what, seen, want);
   endtask

   // Offer one transaction after an optional idle gap; predict on acceptance.
   task automatic send_item(logic [OP_W-1:0] op, logic [STAMP_W-1:0] stamp,
                            logic [SIZE_W-1:0] size, logic [HANDLE_W-1:0] handle);
      int unsigned gap;
      gap = 0;
      while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct && gap < 30) gap++;
      @(negedge clock);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {1'b0, handle, size, stamp};
      do @(posedge clock); while (req_tready !== 1'b1);
      queue_replies.insert(queue_replies.size(), compute_queue_reply(op, stamp, size, handle));
      item_count++;
      if (op == OP_PUSH) last_stamp = stamp;
   endtask

   // Stop offering and wait until every predicted result has arrived.
   task automatic quiesce();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (queue_replies.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= value;
      case (index)
         CSR_BYTE_LIMIT_ENABLE: cfg.byte_limit_enable = value[0];
         CSR_BYTE_LIMIT:        cfg.byte_limit = value[LIMIT_W-1:0];
         CSR_WINDOW_ENABLE:     cfg.window_enable = value[0];
         CSR_WINDOW_LENGTH:     cfg.window_length = value[WINDOW_W-1:0];
         CSR_ENTRY_OVERHEAD:    cfg.entry_overhead = value[OVH_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Drain the queue traffic, then write all five registers.
   task automatic apply_settings(bit byte_en, logic [LIMIT_W-1:0] byte_lim, bit win_en,
                                 logic [WINDOW_W-1:0] win_len, logic [OVH_W-1:0] ovh);
      quiesce();
      write_csr(CSR_BYTE_LIMIT_ENABLE, CSR_DATA_W'(byte_en));
      write_csr(CSR_BYTE_LIMIT, CSR_DATA_W'(byte_lim));
      write_csr(CSR_WINDOW_ENABLE, CSR_DATA_W'(win_en));
      write_csr(CSR_WINDOW_LENGTH, CSR_DATA_W'(win_len));
      write_csr(CSR_ENTRY_OVERHEAD, CSR_DATA_W'(ovh));
   endtask

   // Idling pattern: 0 none, 1 sender, 2 receiver, 3 both lightly.
   task automatic set_idling(int unsigned mode);
      tx_idle_pct  = (mode == 1) ? 51 : (mode == 3) ? 10 : 0;
      rx_stall_pct = (mode == 2) ? 51 : (mode == 3) ? 10 : 0;
   endtask

   // Next push stamp: mostly moving forward, sometimes back, equal or anywhere.
   function automatic logic [STAMP_W-1:0] next_stamp(int unsigned step_max, bit wild);
      int unsigned        pick;
      logic [STAMP_W-1:0] step;
      pick = $urandom_range(99);
      step = STAMP_W'($urandom_range(step_max));
      if (wild && pick < 6)
         return (last_stamp > step) ? last_stamp - step - 1 : '0;
      if (wild && pick < 9)
         return last_stamp;
      if (wild && pick < 12)
         return STAMP_W'({$urandom, $urandom});
      return (STAMP_MAX - last_stamp < step) ? STAMP_MAX : last_stamp + step;
   endfunction

   function automatic logic [SIZE_W-1:0] next_size(int unsigned size_max);
      if ($urandom_range(99) < 8) return SIZE_W'($urandom);
      return SIZE_W'($urandom_range(size_max));
   endfunction

   // Random mix of operations with well-formed pushes in the majority.
   task automatic send_random(int unsigned count, int unsigned size_max,
                              int unsigned step_max);
      int unsigned     pick;
      logic [OP_W-1:0] op;
      repeat (count) begin
         pick = $urandom_range(99);
         op = (pick < 68) ? OP_PUSH : (pick < 94) ? OP_POP :
              (pick < 97) ? OP_CLEAR : OP_UNUSED;
         send_item(op, next_stamp(step_max, 1'b1), next_size(size_max), $urandom);
      end
   endtask

   // Pushes only, with stamps that never go back.
   task automatic push_run(int unsigned count, int unsigned size_max, int unsigned step_max);
      repeat (count) send_item(OP_PUSH, next_stamp(step_max, 1'b0), next_size(size_max), $urandom);
   endtask

   // Field extremes, every operation and the special cases, one at a time.
   task automatic test_directed();
      set_idling(0);
      send_item(OP_POP, '0, '0, '0);
      send_item(OP_CLEAR, '0, '0, '0);
      send_item(OP_UNUSED, STAMP_MAX, SIZE_MAX, '1);
      send_item(OP_PUSH, '0, '0, '0);
      send_item(OP_PUSH, STAMP_MAX, SIZE_MAX, '1);
      send_item(OP_PUSH, 63'd5, 24'd100, 32'hA5A5_5A5A);
      send_item(OP_POP, '0, '0, '0);
      send_item(OP_POP, '0, '0, '0);
      send_item(OP_PUSH, 63'd10, 24'd1, 32'h1);
      send_item(OP_PUSH, 63'd10, 24'd2, 32'h2);
      send_item(OP_CLEAR, '0, '0, '0);
      // Byte budget: oversize drop, eviction, and a drop after a backstep clear.
      apply_settings(1'b1, 32'd200, 1'b0, '0, OVERHEAD_RESET);
      send_item(OP_PUSH, 63'd100, 24'd150, 32'h10);
      send_item(OP_PUSH, 63'd110, 24'd201, 32'h11);
      send_item(OP_PUSH, 63'd120, 24'd50, 32'h12);
      send_item(OP_PUSH, 63'd90, 24'd300, 32'h13);
      // Time window eviction, including the boundary span.
      apply_settings(1'b0, '0, 1'b1, 62'd50, OVERHEAD_RESET);
      send_item(OP_PUSH, 63'd1000, 24'd1, 32'h20);
      send_item(OP_PUSH, 63'd1030, 24'd1, 32'h21);
      send_item(OP_PUSH, 63'd1060, 24'd1, 32'h22);
      send_item(OP_PUSH, 63'd2000, 24'd1, 32'h23);
      send_item(OP_PUSH, 63'd2050, 24'd1, 32'h24);
      send_item(OP_POP, '0, '0, '0);
   endtask

   task automatic test_byte_budget();
      set_idling(1);
      apply_settings(1'b1, 32'd0, 1'b0, '0, OVERHEAD_RESET);
      send_random(30, 3, 50);
      apply_settings(1'b1, 32'd2000, 1'b0, '0, 8'd0);
      send_random(100, 700, 100);
      apply_settings(1'b1, 32'hFFFF_FFFF, 1'b0, '0, 8'hFF);
      send_random(70, 24'hFFFFFF, 1000);
   endtask

   task automatic test_time_window();
      set_idling(2);
      apply_settings(1'b0, '0, 1'b1, '0, OVERHEAD_RESET);
      send_random(60, 200, 3);
      apply_settings(1'b0, '0, 1'b1, 62'd500, OVERHEAD_RESET);
      send_random(100, 300, 200);
      // Widest window: only a span past 2^62 - 1 evicts.
      apply_settings(1'b0, '0, 1'b1, WINDOW_MAX, OVERHEAD_RESET);
      send_item(OP_CLEAR, '0, '0, '0);
      send_item(OP_PUSH, '0, 24'd7, 32'h30);
      send_item(OP_PUSH, {1'b0, WINDOW_MAX}, 24'd7, 32'h31);
      send_item(OP_PUSH, STAMP_MAX, 24'd7, 32'h32);
      send_random(30, 500, 1000);
   endtask

   // Overfill the ring, then evict every entry with one push as large as the byte limit.
   task automatic test_ring_full();
      set_idling(3);
      apply_settings(1'b0, '0, 1'b0, '0, OVERHEAD_RESET);
      send_item(OP_CLEAR, '0, '0, '0);
      last_stamp = '0;
      push_run(300, 100, 20);
      apply_settings(1'b1, 32'(SIZE_MAX), 1'b0, '0, OVERHEAD_RESET);
      push_run(1, 0, 5);
      send_item(OP_PUSH, next_stamp(5, 1'b0), SIZE_MAX, $urandom);
      send_item(OP_PUSH, next_stamp(5, 1'b0), '0, $urandom);
      send_random(20, 100, 20);
   endtask

   // Overhead changed while entries are held, so removals saturate at zero.
   task automatic test_overhead_change();
      set_idling(1);
      apply_settings(1'b0, '0, 1'b0, '0, 8'd0);
      send_item(OP_CLEAR, '0, '0, '0);
      push_run(20, 30, 10);
      apply_settings(1'b0, '0, 1'b0, '0, 8'hFF);
      repeat (24) send_item(OP_POP, '0, '0, '0);
      push_run(10, 30, 10);
      apply_settings(1'b0, '0, 1'b0, '0, 8'd0);
      repeat (5) send_item(OP_POP, '0, '0, '0);
   endtask

   // Long receiver hold-off while the sender keeps offering.
   task automatic test_backpressure();
      set_idling(0);
      apply_settings(1'b1, 32'd3000, 1'b1, 62'd800, 8'd16);
      hold_off_len = HOLD_CYCLES;
      send_random(80, 600, 300);
   endtask

   task automatic test_random_mix();
      for (int unsigned phase = 0; phase < 8; phase++) begin
         set_idling(phase % 4);
         case (phase)
            0: begin
               apply_settings(1'b1, 32'd4000, 1'b1, 62'd1500, 8'd32);
               send_random(125, 1200, 400);
            end
            1: begin
               apply_settings(1'b0, '0, 1'b0, '0, 8'd32);
               send_random(125, 5000, 1000);
            end
            2: begin
               apply_settings(1'b1, 32'd300, 1'b0, '0, 8'd0);
               send_random(125, 200, 50);
            end
            3: begin
               apply_settings(1'b0, '0, 1'b1, 62'd100, 8'hFF);
               send_random(125, 1000, 60);
            end
            4: begin
               apply_settings(1'b1, 32'hFFFF_FFFF, 1'b1, WINDOW_MAX, 8'hFF);
               send_random(125, 24'hFFFFFF, 32'hFFFF_FFFF);
            end
            5: begin
               apply_settings(1'b1, 32'd100000, 1'b1, 62'd5000, 8'd16);
               send_random(125, 20000, 2000);
            end
            6: begin
               apply_settings(1'b1, 32'd1000, 1'b1, '0, 8'd8);
               send_random(125, 300, 3);
            end
            default: begin
               apply_settings(1'b0, '0, 1'b1, 62'd1000000, 8'd200);
               send_random(125, 100, 100000);
            end
         endcase
      end
   endtask

   // Receiver: random stalls, or a long hold-off when one is requested.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_len != 0) begin
            rsp_tready <= 1'b0;
            hold_left = hold_off_len;
            hold_off_len = 0;
            repeat (hold_left - 1) @(negedge clock);
         end else begin
            rsp_tready <= ($urandom_range(99) >= rx_stall_pct);
         end
      end
   end

   // Result checking against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         reply_count++;
         if (queue_replies.size() == 0) begin
            report_mismatch("result with nothing predicted", rsp_tdata[63:0], '0);
         end else begin
            want_reply = queue_replies[0];
            queue_replies.delete(0);
            if (rsp_tdata[0] !== want_reply.accepted)
               report_mismatch("accepted", rsp_tdata[0], want_reply.accepted);
            if (rsp_tdata[1] !== want_reply.backstep)
               report_mismatch("cleared_by_backstep", rsp_tdata[1], want_reply.backstep);
            if (rsp_tdata[10:2] !== want_reply.evicted)
               report_mismatch("evicted_count", rsp_tdata[10:2], want_reply.evicted);
            if (rsp_tdata[11] !== want_reply.out_valid)
               report_mismatch("out_valid", rsp_tdata[11], want_reply.out_valid);
            if (rsp_tdata[43:12] !== want_reply.out_handle)
               report_mismatch("out_handle", rsp_tdata[43:12], want_reply.out_handle);
            if (rsp_tdata[106:44] !== want_reply.out_stamp)
               report_mismatch("out_stamp", rsp_tdata[106:44], want_reply.out_stamp);
            if (rsp_tdata[130:107] !== want_reply.out_bytes)
               report_mismatch("out_bytes", rsp_tdata[130:107], want_reply.out_bytes);
            if (rsp_tdata[139:131] !== want_reply.entry_count)
               report_mismatch("entry_count", rsp_tdata[139:131], want_reply.entry_count);
            if (rsp_tdata[179:140] !== want_reply.byte_total)
               report_mismatch("byte_total", rsp_tdata[179:140], want_reply.byte_total);
         end
      end
   end

   // Watchdog on cycles with no transaction on either stream.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready === 1'b1) ||
          (rsp_tvalid === 1'b1 && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no transaction for %0d cycles", STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // Main sequence.
   initial begin
      reset            = 1'b1;
      req_tvalid       = 1'b0;
      req_tdata        = '0;
      req_tuser        = '0;
      csr_write_enable = 1'b0;
      csr_index        = '0;
      csr_write_data   = '0;
      hold_off_len     = 0;
      quiet_cycles     = 0;
      last_stamp       = '0;
      ring_head        = 0;
      ring_fill        = 0;
      ring_bytes       = 0;
      cfg              = '0;
      cfg.entry_overhead = OVERHEAD_RESET;
      set_idling(0);
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_byte_budget();
      test_time_window();
      test_ring_full();
      test_overhead_change();
      test_backpressure();
      test_random_mix();

      quiesce();
      repeat (20) @(posedge clock);
      $display("Ran %0d transactions, %0d results: %0d pushes stored, %0d dropped, %0d backsteps.",
               item_count, reply_count, stored_count, dropped_count, backstep_count);
      $display("Evictions %0d (peak %0d in one push), pops with entry %0d, on empty %0d.",
               evict_total, evict_peak, pop_hit_count, pop_empty_count);
      if (mismatch_count == 0 && queue_replies.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/tbbsq_pkg.sv
hw/rtl/tbbsq_ctrl.sv
hw/rtl/tbbsq_datapath.sv
hw/rtl/time_and_byte_bounded_snapshot_queue_top.sv
hw/rtl/tbbsq_checker.sv
tb/tb.sv
